// ===== hw/rtl/cdes_pkg.sv =====
// Shared constants and helper functions for the calendar date to epoch seconds converter.
package cdes_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned EpochW = 32;

  // Quotient width of a 13-bit value divided by 100.
  localparam int unsigned QuotW  = 7;
  // Width of the time-of-day second count and of the in-year day offset.
  localparam int unsigned HmsW   = 17;
  localparam int unsigned DoffW  = 9;

  // Days from the start of year 0 to the start of the epoch year.
  localparam logic [EpochW-1:0] EpochDays   = 32'd719528;
  localparam logic [EpochW-1:0] SecsPerDay  = 32'd86400;
  // Reciprocal of 100 scaled by 2^19; exact for every dividend below 8192.
  localparam logic [12:0]       Recip100    = 13'd5243;
  localparam int unsigned       Recip100Sh  = 19;

  // Whole-month day counts ahead of the given month; zero for codes that mean nothing.
  function automatic logic [DoffW-1:0] cum_days(input logic [MonthW-1:0] m);
    logic [DoffW-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Floor of x / 100 through a reciprocal multiply.
  function automatic logic [QuotW-1:0] div100(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'(Recip100);
    return p[Recip100Sh +: QuotW];
  endfunction

endpackage

// ===== hw/rtl/calendar_date_to_epoch_seconds.sv =====
// Top level: pipelined conversion of a calendar date and time of day to Unix seconds.
// Each accepted input beat leaves as one result beat from the output register of the last stage.
// Throughput is one beat per cycle; the five register stages advance together whenever the
// output register is empty or being taken, so back-pressure freezes the whole pipe in place.
// The critical stages are the three parallel reciprocal multiplies for the century division
// and the 32 by 17 bit multiply by the seconds in a day. Reset (rst_n low, synchronous) clears
// the stage valid bits only; data registers are not reset.
module calendar_date_to_epoch_seconds (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cdes_pkg::YearW-1:0]   in_year,
  input  logic [cdes_pkg::MonthW-1:0]  in_month,
  input  logic [cdes_pkg::DayW-1:0]    in_day_of_month,
  input  logic [cdes_pkg::HourW-1:0]   in_hour,
  input  logic [cdes_pkg::MinW-1:0]    in_minute,
  input  logic [cdes_pkg::SecW-1:0]    in_second,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cdes_pkg::EpochW-1:0]  out_epoch_seconds,
  output logic                         out_invalid
);
  import cdes_pkg::*;

  // The pipe moves as one when the output register can take a new beat.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 1: range check, month table, time of day, and the century divisions.
  // Leap rule needs y/100; the year count needs (y+99)/100 and (y+399)/400, where
  // the latter is ((y+399)>>2)/100.
  // ---------------------------------------------------------------------------
  logic              v1_r, inv1_r, late1_r;
  logic [YearW-1:0]  y1_r;
  logic [QuotW-1:0]  qy1_r, q100_1_r, q400_1_r;
  logic [DoffW-1:0]  cum1_r;
  logic [DayW-1:0]   dm1_1_r;
  logic [HmsW-1:0]   hms1_r;

  logic              inv1_nxt, late1_nxt;
  logic [12:0]       y99, y399;
  logic [QuotW-1:0]  qy1_nxt, q100_1_nxt, q400_1_nxt;
  logic [HmsW-1:0]   hms1_nxt;

  always_comb begin
    inv1_nxt   = (in_month == 4'd0) || (in_month > 4'd12) || (in_day_of_month == 5'd0);
    late1_nxt  = in_month >= 4'd3;
    y99        = 13'(in_year) + 13'd99;
    y399       = 13'(in_year) + 13'd399;
    qy1_nxt    = div100(13'(in_year));
    q100_1_nxt = div100(y99);
    q400_1_nxt = div100(13'(y399[12:2]));
    hms1_nxt   = HmsW'(in_hour) * HmsW'(3600) + HmsW'(in_minute) * HmsW'(60)
               + HmsW'(in_second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv1_r   <= inv1_nxt;
      late1_r  <= late1_nxt;
      y1_r     <= in_year;
      qy1_r    <= qy1_nxt;
      q100_1_r <= q100_1_nxt;
      q400_1_r <= q400_1_nxt;
      cum1_r   <= cum_days(in_month);
      dm1_1_r  <= in_day_of_month - 5'd1;
      hms1_r   <= hms1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: whole-year day count relative to the epoch, wrapping at 32 bits so
  // years before 1970 come out as two's complement, plus the in-year offset.
  // ---------------------------------------------------------------------------
  logic              v2_r, inv2_r;
  logic [EpochW-1:0] dyear2_r;
  logic [DoffW-1:0]  doff2_r;
  logic [HmsW-1:0]   hms2_r;

  logic [20:0]       y365;
  logic [10:0]       q4;
  logic [13:0]       back100;
  logic              leap;
  logic [EpochW-1:0] dyear2_nxt;
  logic [DoffW-1:0]  doff2_nxt;

  always_comb begin
    y365       = 21'(y1_r) * 21'd365;
    q4         = 11'((13'(y1_r) + 13'd3) >> 2);
    back100    = 14'(qy1_r) * 14'd100;
    leap       = (y1_r[1:0] == 2'b00)
               && ((back100 != 14'(y1_r)) || (qy1_r[1:0] == 2'b00));
    dyear2_nxt = EpochW'(y365) + EpochW'(q4) - EpochW'(q100_1_r) + EpochW'(q400_1_r)
               - EpochDays;
    doff2_nxt  = cum1_r + DoffW'(dm1_1_r) + DoffW'(leap && late1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv2_r   <= inv1_r;
      dyear2_r <= dyear2_nxt;
      doff2_r  <= doff2_nxt;
      hms2_r   <= hms1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: total day count.
  // ---------------------------------------------------------------------------
  logic              v3_r, inv3_r;
  logic [EpochW-1:0] days3_r;
  logic [HmsW-1:0]   hms3_r;
  logic [EpochW-1:0] days3_nxt;

  assign days3_nxt = dyear2_r + EpochW'(doff2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv3_r  <= inv2_r;
      days3_r <= days3_nxt;
      hms3_r  <= hms2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: days to seconds, low 32 bits of the product.
  // ---------------------------------------------------------------------------
  logic              v4_r, inv4_r;
  logic [EpochW-1:0] dsec4_r;
  logic [HmsW-1:0]   hms4_r;
  logic [EpochW-1:0] dsec4_nxt;

  assign dsec4_nxt = days3_r * SecsPerDay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv4_r  <= inv3_r;
      dsec4_r <= dsec4_nxt;
      hms4_r  <= hms3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: add the time of day and force zero for a bad month or day.
  // ---------------------------------------------------------------------------
  logic              out_valid_r, out_invalid_r;
  logic [EpochW-1:0] out_secs_r;
  logic [EpochW-1:0] out_secs_nxt;

  assign out_secs_nxt = inv4_r ? '0 : (dsec4_r + EpochW'(hms4_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_invalid_r <= inv4_r;
      out_secs_r    <= out_secs_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_invalid       = out_invalid_r;
  assign out_epoch_seconds = out_secs_r;

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_invalid_r |-> out_secs_r == '0)
    else $error("flagged result carries a nonzero second count");

  a_bad_month_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_month == 4'd0) || (in_month > 4'd12))
    |=> v1_r && inv1_r)
    else $error("bad month not flagged in the first stage");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !inv2_r |-> doff2_r <= 9'd365)
    else $error("in-year day offset beyond a year");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v4_r) && $stable(dsec4_r) && $stable(v1_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== sim/calendar_date_to_epoch_seconds_tb.sv =====
// Self-checking testbench for the calendar date to epoch seconds converter.
module calendar_date_to_epoch_seconds_tb;

  import cdes_pkg::*;

  // Month codes that the calendar rules single out.
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [MonthW-1:0] MonthMax = 4'd15;

  localparam int unsigned EpochYear   = 1970;
  localparam int unsigned PipeLatency = 5;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned HangLimit   = 5000;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } date_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch_seconds;
    logic              invalid;
  } epoch_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [YearW-1:0]    in_year = '0;
  logic [MonthW-1:0]   in_month = '0;
  logic [DayW-1:0]     in_day_of_month = '0;
  logic [HourW-1:0]    in_hour = '0;
  logic [MinW-1:0]     in_minute = '0;
  logic [SecW-1:0]     in_second = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [EpochW-1:0]   out_epoch_seconds;
  logic                out_invalid;

  // Percent chances, per cycle, that the sender holds off and the receiver stalls.
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  // Results still owed by the block, oldest first.
  epoch_result_t       epochs_due[$];
  epoch_result_t       due_head;
  int unsigned         mismatch_count = 0;
  int unsigned         quiet_cycles = 0;

  calendar_date_to_epoch_seconds u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_year           (in_year),
    .in_month          (in_month),
    .in_day_of_month   (in_day_of_month),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds),
    .out_invalid       (out_invalid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Days from January 1 of year 0 to January 1 of year y, counting every
  // Gregorian leap year in [0, y-1]: one per four years, less one per century,
  // plus one per four centuries.
  function automatic longint days_before_year(input longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic bit is_leap_year(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Days in the whole months that precede month m of a common year.
  function automatic longint days_before_month(input logic [MonthW-1:0] m);
    case (m)
      4'd2:    return 31;
      4'd3:    return 59;
      4'd4:    return 90;
      4'd5:    return 120;
      4'd6:    return 151;
      4'd7:    return 181;
      4'd8:    return 212;
      4'd9:    return 243;
      4'd10:   return 273;
      4'd11:   return 304;
      4'd12:   return 334;
      default: return 0;
    endcase
  endfunction

  // The exact signed second count is formed first and only then cut to 32 bits,
  // so years before 1970 and counts past 2^32 wrap the way two's complement does.
  // Time-of-day fields are added raw, whatever their value.
  function automatic epoch_result_t date_to_epoch(input date_t d);
    epoch_result_t r;
    longint        days;
    longint        secs;
    if (d.month < MonthJan || d.month > MonthDec || d.day == '0) begin
      r.epoch_seconds = '0;
      r.invalid       = 1'b1;
      return r;
    end
    days = days_before_year(longint'(d.year)) - days_before_year(longint'(EpochYear));
    days += days_before_month(d.month);
    if (d.month >= MonthMar && is_leap_year(longint'(d.year))) days += 1;
    days += longint'(d.day) - 1;
    secs = days * 86400 + longint'(d.hour) * 3600 + longint'(d.minute) * 60
         + longint'(d.second);
    r.epoch_seconds = secs[EpochW-1:0];
    r.invalid       = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: the expectation is queued on the input beat and retired on the
  // output beat. Both happen in one process so that an item that came out in
  // the same edge it went in would still find its expectation waiting.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        epochs_due.push_back(date_to_epoch({in_year, in_month, in_day_of_month,
                                            in_hour, in_minute, in_second}));
      end
      if (out_valid && out_ready) begin
        if (epochs_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected, got epoch_seconds %0d invalid %0b",
                   $time, out_epoch_seconds, out_invalid);
        end else begin
          due_head = epochs_due.pop_front();
          if (out_epoch_seconds !== due_head.epoch_seconds) begin
            mismatch_count++;
            $display("%0t: epoch_seconds mismatch, expected %0d, got %0d",
                     $time, due_head.epoch_seconds, out_epoch_seconds);
          end
          if (out_invalid !== due_head.invalid) begin
            mismatch_count++;
            $display("%0t: invalid mismatch, expected %0b, got %0b",
                     $time, due_head.invalid, out_invalid);
          end
        end
      end
    end
  end

  // The receiver stalls at random; with a zero chance it takes every beat.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: a long run of cycles with no beat on either channel means the
  // block has hung, so the run ends there as a failure.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HangLimit) begin
      $display("%0t: no beat for %0d cycles", $time, HangLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic date_t make_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d, input int unsigned h,
                                      input int unsigned mi, input int unsigned s);
    date_t r;
    r.year   = YearW'(y);
    r.month  = MonthW'(m);
    r.day    = DayW'(d);
    r.hour   = HourW'(h);
    r.minute = MinW'(mi);
    r.second = SecW'(s);
    return r;
  endfunction

  // Mostly ordinary dates inside the block's working years, with a share of
  // far-off years, bad month or day codes and raw time fields past their range.
  function automatic date_t random_date();
    date_t r;
    r.year   = ($urandom_range(0, 99) < 85) ? YearW'($urandom_range(1970, 2099))
                                            : YearW'($urandom_range(0, 4095));
    r.month  = ($urandom_range(0, 99) < 90) ? MonthW'($urandom_range(1, 12))
                                            : MonthW'($urandom_range(0, MonthMax));
    r.day    = ($urandom_range(0, 99) < 92) ? DayW'($urandom_range(1, 31))
                                            : DayW'($urandom_range(0, 31));
    r.hour   = ($urandom_range(0, 99) < 95) ? HourW'($urandom_range(0, 23))
                                            : HourW'($urandom_range(0, 31));
    r.minute = ($urandom_range(0, 99) < 95) ? MinW'($urandom_range(0, 59))
                                            : MinW'($urandom_range(0, 63));
    r.second = ($urandom_range(0, 99) < 95) ? SecW'($urandom_range(0, 59))
                                            : SecW'($urandom_range(0, 63));
    return r;
  endfunction

  // Presents one date and returns in the time step of the edge that took it.
  // Valid is left high on return; the next call either keeps it high for a
  // back-to-back beat or lowers it for an idle gap, never both in one step.
  task automatic send_date(input date_t d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_year         <= d.year;
    in_month        <= d.month;
    in_day_of_month <= d.day;
    in_hour         <= d.hour;
    in_minute       <= d.minute;
    in_second       <= d.second;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The sender goes quiet until every expected result has come back, then
  // lets a few more cycles pass so that a stray extra beat would be caught.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (epochs_due.size() != 0) @(posedge clk);
    repeat (PipeLatency + 3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The ends of the working range and of the year and time fields' bit widths, and the top of the day field's.
  task automatic test_field_extremes();
    send_date(make_date(1970, 1, 1, 0, 0, 0));
    send_date(make_date(2099, 12, 31, 23, 59, 59));
    send_date(make_date(0, 1, 1, 0, 0, 0));
    send_date(make_date(4095, 12, 31, 31, 63, 63));
    send_date(make_date(1969, 12, 31, 23, 59, 59));
    // The signed 32-bit rollover instant and the unsigned wrap near 2106.
    send_date(make_date(2038, 1, 19, 3, 14, 8));
    send_date(make_date(2106, 2, 7, 6, 28, 16));
    wait_for_drain();
  endtask

  // Leap days by the four-year, century and four-century rules, on both
  // sides of the end of February.
  task automatic test_leap_rules();
    send_date(make_date(2000, 2, 29, 12, 0, 0));
    send_date(make_date(2000, 3, 1, 0, 0, 0));
    send_date(make_date(2024, 2, 29, 23, 59, 59));
    send_date(make_date(2024, 3, 1, 0, 0, 0));
    send_date(make_date(2100, 2, 28, 0, 0, 0));
    send_date(make_date(2100, 3, 1, 0, 0, 0));
    send_date(make_date(1900, 3, 1, 0, 0, 0));
    wait_for_drain();
  endtask

  // Days past a month's true length roll on into the next month.
  task automatic test_short_months();
    send_date(make_date(2023, MonthFeb, 30, 0, 0, 0));
    send_date(make_date(2024, MonthFeb, 31, 1, 2, 3));
    send_date(make_date(2023, 4, 31, 10, 20, 30));
    wait_for_drain();
  endtask

  // Month codes outside January to December and a zero day give the flagged
  // zero result, whatever the other fields hold.
  task automatic test_bad_codes();
    send_date(make_date(2000, 0, 15, 1, 1, 1));
    send_date(make_date(2000, 13, 15, 1, 1, 1));
    send_date(make_date(2000, MonthMax, 31, 31, 63, 63));
    send_date(make_date(2000, MonthJan, 0, 0, 0, 0));
    send_date(make_date(4095, 0, 0, 31, 63, 63));
    send_date(make_date(1970, 14, 1, 0, 0, 0));
    wait_for_drain();
  endtask

  task automatic test_random_dates(input int unsigned count, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_date(random_date());
    wait_for_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed cases at full rate, then random phases that
  // move idle gaps and stalls through every phase of the pipe.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_leap_rules();
    test_short_months();
    test_bad_codes();

    test_random_dates(500, 0, 0);
    test_random_dates(480, 76, 0);
    test_random_dates(480, 0, 76);
    test_random_dates(470, 32, 32);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
